/* rtl/bpc_pkg.sv */
// shared types, constants and register indexes for the pressure compensation block
package bpc_pkg;

  localparam int unsigned DivStages = 32;

  typedef enum logic [2:0] {
    REG_OSS    = 3'd0,
    REG_AC1AC2 = 3'd1,
    REG_AC3AC4 = 3'd2,
    REG_AC5AC6 = 3'd3,
    REG_B1B2   = 3'd4,
    REG_MCMD   = 3'd5
  } reg_idx_e;

  localparam logic [31:0] C_4000   = 32'd4000;
  localparam logic [31:0] C_32768  = 32'd32768;
  localparam logic [31:0] C_50000  = 32'd50000;
  localparam logic [31:0] C_3038   = 32'd3038;
  localparam logic [31:0] C_M7357  = 32'hFFFF_E343;
  localparam logic [31:0] C_3791   = 32'd3791;
  localparam logic [31:0] PRES_MAX = 32'd262143;

  typedef struct packed {
    logic [1:0]  oss;
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
  } coef_t;

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
    asr = 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

/* rtl/bpc_if.sv */
// valid/ready channel interfaces for items, results and configuration writes
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [18:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] temperature;
  logic [17:0] pressure;
  logic        error;
  modport source (output valid, temperature, pressure, error, input ready);
  modport sink (input valid, temperature, pressure, error, output ready);
endinterface

interface bpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/barometric_pressure_compensation_top.sv */
// order: temp stages, temp divider, pres stages, pres divider, correction, output reg
// one request per cycle unless stalled; two 32-stage restoring dividers set the depth
// the whole pipe advances when the output register is empty or being taken
// a full output register holds while the pipe stalls; nothing is lost or repeated
// reset clears valid bits and configuration registers; payload registers are not reset
module barometric_pressure_compensation_top (
  input logic clk_i,
  input logic rst_ni,
  bpc_in_if.sink    in_if,
  bpc_out_if.source out_if,
  bpc_cfg_if.sink   cfg_if
);
  import bpc_pkg::*;

  coef_t coef_q;

  // config writes, unknown index dropped
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_OSS:    coef_q.oss     <= cfg_if.data[1:0];
        REG_AC1AC2: coef_q.ac1_ac2 <= cfg_if.data;
        REG_AC3AC4: coef_q.ac3_ac4 <= cfg_if.data;
        REG_AC5AC6: coef_q.ac5_ac6 <= cfg_if.data;
        REG_B1B2:   coef_q.b1_b2   <= cfg_if.data;
        REG_MCMD:   coef_q.mc_md   <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // global enable: pipe moves when output slot free or drained this cycle
  logic en;
  logic out_v_q;
  assign en = !out_v_q || out_if.ready;
  assign in_if.ready = en;

  logic        tv, terr;
  logic [31:0] b5;
  logic [18:0] up;
  bpc_temp u_temp (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (in_if.valid),
    .ut_i    (in_if.raw_temperature),
    .up_i    (in_if.raw_pressure),
    .coef_i  (coef_q),
    .valid_o (tv),
    .b5_o    (b5),
    .err_o   (terr),
    .up_o    (up)
  );

  logic        pv, perr;
  logic [15:0] tmp;
  logic [17:0] prs;
  bpc_pres u_pres (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (tv),
    .b5_i    (b5),
    .err_i   (terr),
    .up_i    (up),
    .coef_i  (coef_q),
    .valid_o (pv),
    .temp_o  (tmp),
    .pres_o  (prs),
    .err_o   (perr)
  );

  // output register
  logic [15:0] t_q;
  logic [17:0] p_q;
  logic        e_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= pv;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q <= tmp;
      p_q <= prs;
      e_q <= perr;
    end
  end

  assign out_if.valid       = out_v_q;
  assign out_if.temperature = t_q;
  assign out_if.pressure    = p_q;
  assign out_if.error       = e_q;
endmodule

/* rtl/bpc_udiv.sv */
// pipelined unsigned restoring divider, one quotient bit per stage, side payload carried along
module bpc_udiv #(
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      num_i,
  input  logic [31:0]      den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [31:0]      quo_o,
  output logic [SideW-1:0] side_o
);
  import bpc_pkg::*;

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic             vin;
    logic [31:0]      rin, nin, din;
    logic [SideW-1:0] sin;
    logic             vld_q;
    logic [31:0]      rem_q, num_q, den_q;
    logic [SideW-1:0] side_q;
    logic [32:0]      trial;
    logic [32:0]      sh;

    if (s == 0) begin : g_head
      assign vin = valid_i;
      assign rin = '0;
      assign nin = num_i;
      assign din = den_i;
      assign sin = side_i;
    end else begin : g_body
      assign vin = g_stage[s-1].vld_q;
      assign rin = g_stage[s-1].rem_q;
      assign nin = g_stage[s-1].num_q;
      assign din = g_stage[s-1].den_q;
      assign sin = g_stage[s-1].side_q;
    end

    always_comb begin
      sh    = {rin, nin[31]};
      trial = sh - {1'b0, din};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!trial[32]) begin
          rem_q <= trial[31:0];
          num_q <= {nin[30:0], 1'b1};
        end else begin
          rem_q <= sh[31:0];
          num_q <= {nin[30:0], 1'b0};
        end
        den_q  <= din;
        side_q <= sin;
      end
    end
  end

  assign valid_o = g_stage[DivStages-1].vld_q;
  assign quo_o   = g_stage[DivStages-1].num_q;
  assign side_o  = g_stage[DivStages-1].side_q;
endmodule

/* rtl/bpc_temp.sv */
// temperature front end: x1, divisor, and signed division by pipelined divider
module bpc_temp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [15:0]         ut_i,
  input  logic [18:0]         up_i,
  input  bpc_pkg::coef_t      coef_i,
  output logic                valid_o,
  output logic [31:0]         b5_o,
  output logic                err_o,
  output logic [18:0]         up_o
);
  import bpc_pkg::*;

  localparam int unsigned SideW = 32 + 1 + 1 + 19;

  logic        v1_q, v2_q;
  logic [31:0] dif_q, x1_q, d_q, num_q;
  logic [18:0] up1_q, up2_q;
  logic        ng;
  logic [31:0] dif_d, prod, x1_d, num_d, d_d;
  logic [31:0] an, ad;
  logic [SideW-1:0] side_out;
  logic [31:0] quo;

  always_comb begin
    dif_d = {16'd0, ut_i} - {16'd0, coef_i.ac5_ac6[15:0]};
    prod  = dif_q * {16'd0, coef_i.ac5_ac6[31:16]};
    x1_d  = asr(prod, 15);
    num_d = sx16(coef_i.mc_md[31:16]) << 11;
    d_d   = x1_d + sx16(coef_i.mc_md[15:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dif_q <= dif_d;
      up1_q <= up_i;
      x1_q  <= x1_d;
      d_q   <= d_d;
      num_q <= num_d;
      up2_q <= up1_q;
    end
  end

  always_comb begin
    an = num_q[31] ? 32'd0 - num_q : num_q;
    ad = d_q[31] ? 32'd0 - d_q : d_q;
    ng = num_q[31] ^ d_q[31];
  end

  bpc_udiv #(.SideW(SideW)) u_div (
    .clk_i, .rst_ni, .en_i,
    .valid_i (v2_q),
    .num_i   (an),
    .den_i   (ad),
    .side_i  ({x1_q, ng, (d_q == 32'd0), up2_q}),
    .valid_o (valid_o),
    .quo_o   (quo),
    .side_o  (side_out)
  );

  assign b5_o  = side_out[SideW-1 -: 32] + (side_out[20] ? 32'd0 - quo : quo);
  assign err_o = side_out[19];
  assign up_o  = side_out[18:0];
endmodule

/* rtl/bpc_pres.sv */
// pressure path: b3/b4/b7 terms, pipelined unsigned division and final correction
module bpc_pres (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [31:0]    b5_i,
  input  logic           err_i,
  input  logic [18:0]    up_i,
  input  bpc_pkg::coef_t coef_i,
  output logic           valid_o,
  output logic [15:0]    temp_o,
  output logic [17:0]    pres_o,
  output logic           err_o
);
  import bpc_pkg::*;

  localparam int unsigned SideW = 16 + 1 + 1;
  logic [1:0] oss;
  assign oss = coef_i.oss;

  // stage a: b6, temperature
  logic        va_q, vb_q, vc_q, vd_q, ve_q;
  logic [31:0] b6_q;
  logic [15:0] ta_q;
  logic        ea_q;
  logic [18:0] upa_q, upb_q, upc_q, upd_q;
  logic [31:0] t_full;
  logic [15:0] t_sat;
  always_comb begin
    t_full = asr(b5_i + 32'd8, 4);
    if ($signed(t_full) > 32'sd32767) t_sat = 16'h7FFF;
    else if ($signed(t_full) < -32'sd32768) t_sat = 16'h8000;
    else t_sat = t_full[15:0];
  end

  // stage b: sq, ac2*b6, ac3*b6
  logic [31:0] sq_q, ac2b6_q, ac3b6_q;
  // stage c: b2*sq, b1*sq
  logic [31:0] x1c_q, x2c_q, x1d_q, x2d_q;
  // stage d: b3, x3
  logic [31:0] b3_q, x3_q;
  // stage e: b4, b7
  logic [31:0] b4_q, b7_q;
  logic [15:0] tb_q, tc_q, td_q, te_q;
  logic        eb_q, ec_q, ed_q, ee_q;

  logic [31:0] sq_d, b3_d, x3_d, x3p_d, b4m, b7_d;
  always_comb begin
    sq_d  = asr(b6_q * b6_q, 12);
    x3p_d = asr(x1c_q, 11) + asr(x2c_q, 11);
    b3_d  = asr(((sx16(coef_i.ac1_ac2[31:16]) * 32'd4 + x3p_d) << oss) + 32'd2, 2);
    x3_d  = asr(asr(x1d_q, 13) + asr(x2d_q, 16) + 32'd2, 2);
    b4m   = {16'd0, coef_i.ac3_ac4[15:0]} * (x3_q + C_32768);
    b7_d  = ({13'd0, upd_q} - b3_q) * (C_50000 >> oss);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {va_q, vb_q, vc_q, vd_q, ve_q} <= '0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b6_q  <= b5_i - C_4000;
      ta_q  <= t_sat;
      ea_q  <= err_i;
      upa_q <= up_i;
      sq_q    <= sq_d;
      ac2b6_q <= sx16(coef_i.ac1_ac2[15:0]) * b6_q;
      ac3b6_q <= sx16(coef_i.ac3_ac4[31:16]) * b6_q;
      tb_q <= ta_q;
      eb_q <= ea_q;
      upb_q <= upa_q;
      x1c_q <= sx16(coef_i.b1_b2[15:0]) * sq_q;
      x2c_q <= ac2b6_q;
      x1d_q <= ac3b6_q;
      x2d_q <= sx16(coef_i.b1_b2[31:16]) * sq_q;
      tc_q <= tb_q;
      ec_q <= eb_q;
      upc_q <= upb_q;
      b3_q <= b3_d;
      x3_q <= x3_d;
      td_q <= tc_q;
      ed_q <= ec_q;
      upd_q <= upc_q;
      b4_q <= b4m >> 15;
      b7_q <= b7_d;
      te_q <= td_q;
      ee_q <= ed_q;
    end
  end

  logic        b4z, big;
  logic [31:0] dnum;
  always_comb begin
    b4z  = (b4_q == 32'd0) | ee_q;
    big  = b7_q[31];
    dnum = big ? b7_q : {b7_q[30:0], 1'b0};
  end

  logic        vq;
  logic [31:0] quo;
  logic [SideW-1:0] sd;
  bpc_udiv #(.SideW(SideW)) u_div (
    .clk_i, .rst_ni, .en_i,
    .valid_i (ve_q),
    .num_i   (dnum),
    .den_i   (b4_q),
    .side_i  ({te_q, b4z, big}),
    .valid_o (vq),
    .quo_o   (quo),
    .side_o  (sd)
  );

  // correction: three register stages
  logic        vf_q, vg_q, vh_q;
  logic [31:0] pf_q, pg_q, sqf_q, x1g_q, x2g_q;
  logic [15:0] tf_q, tg_q, th_q;
  logic        ef_q, eg_q, eh_q;
  logic [31:0] p_d, xs, pfin;
  logic [17:0] psat;
  always_comb begin
    p_d = sd[0] ? {quo[30:0], 1'b0} : quo;
    xs  = asr(p_d, 8);
    pfin = pg_q + asr(asr(x1g_q, 16) + asr(x2g_q, 16) + C_3791, 4);
    if (pfin[31]) psat = '0;
    else if (pfin > PRES_MAX) psat = PRES_MAX[17:0];
    else psat = pfin[17:0];
  end

  logic [31:0] sqf_d;
  assign sqf_d = xs * xs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {vf_q, vg_q, vh_q} <= '0;
    end else if (en_i) begin
      vf_q <= vq;
      vg_q <= vf_q;
      vh_q <= vg_q;
    end
  end

  logic [17:0] ph_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pf_q  <= p_d;
      tf_q  <= sd[SideW-1 -: 16];
      ef_q  <= sd[1];
      sqf_q <= sqf_d;
      pg_q  <= pf_q;
      x1g_q <= sqf_q * C_3038;
      x2g_q <= C_M7357 * pf_q;
      tg_q  <= tf_q;
      eg_q  <= ef_q;
      ph_q  <= eg_q ? '0 : psat;
      th_q  <= eg_q ? '0 : tg_q;
      eh_q  <= eg_q;
    end
  end

  assign valid_o = vh_q;
  assign temp_o  = th_q;
  assign pres_o  = ph_q;
  assign err_o   = eh_q;
endmodule
